[rtl/core/assert_macros.svh]
// assertion macros shared by the queue rtl
// expects clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while in reset
`define PMQ_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pmq assertion failed");

// next-cycle implication, off while in reset
`define PMQ_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pmq assertion failed");

`endif

[rtl/core/pmq_pkg.sv]
// types, constants and status codes for the priority message queue
// no dependencies
`timescale 1ns / 1ps

package pmq_pkg;

    localparam int QUEUE_DEPTH = 128;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int MAXMSG_W    = 8;
    localparam int LEN_W       = 10;
    localparam int PRIO_W      = 15;
    localparam int HANDLE_W    = 32;
    localparam int STATUS_W    = 3;
    localparam int CFG_IDX_W   = 1;
    localparam int CMP_W       = (CNT_W > MAXMSG_W) ? CNT_W : MAXMSG_W;

    localparam logic [MAXMSG_W-1:0] MAX_MESSAGES_RST     = MAXMSG_W'(100);
    localparam logic [LEN_W-1:0]    MAX_MESSAGE_SIZE_RST = LEN_W'(1000);

    localparam logic [CFG_IDX_W-1:0] REG_MAX_MESSAGES     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_MESSAGE_SIZE = 1'b1;

    localparam logic FUNC_SEND    = 1'b0;
    localparam logic FUNC_RECEIVE = 1'b1;

    localparam logic [1:0] MODE_READ_ONLY  = 2'd1;
    localparam logic [1:0] MODE_WRITE_ONLY = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL       = 3'd1;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_READ_ONLY  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY      = 3'd4;
    localparam logic [STATUS_W-1:0] ST_SMALL_BUF  = 3'd5;
    localparam logic [STATUS_W-1:0] ST_WRITE_ONLY = 3'd6;

    typedef struct packed {
        logic                func;
        logic [1:0]          access_mode;
        logic [HANDLE_W-1:0] payload_handle;
        logic [LEN_W-1:0]    length;
        logic [PRIO_W-1:0]   priority_req;
    } req_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HANDLE_W-1:0] out_handle;
        logic [LEN_W-1:0]    out_length;
        logic [PRIO_W-1:0]   out_priority;
    } rsp_item_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [LEN_W-1:0]    length;
        logic [PRIO_W-1:0]   prio;
    } entry_t;

    typedef struct packed {
        logic                insert;
        logic                pop;
        logic [STATUS_W-1:0] status;
    } op_t;

    typedef struct packed {
        logic             insert;
        logic             pop;
        logic [CNT_W-1:0] count;
        entry_t           new_entry;
    } cell_ctrl_t;

endpackage

[rtl/core/pmq_ctrl.sv]
// request checks: picks status and decides insert or pop
// depends on pmq_pkg
`timescale 1ns / 1ps

module pmq_ctrl (
    input  pmq_pkg::req_item_t              request,
    input  logic [pmq_pkg::CNT_W-1:0]       count,
    input  logic [pmq_pkg::MAXMSG_W-1:0]    max_messages,
    input  logic [pmq_pkg::LEN_W-1:0]       max_message_size,
    output pmq_pkg::op_t                    op
);
    import pmq_pkg::*;

    logic full;
    logic empty;

    assign full  = (CMP_W'(count) >= CMP_W'(max_messages)) ||
                   (CMP_W'(count) >= CMP_W'(QUEUE_DEPTH));
    assign empty = (count == '0);

    always_comb
    begin
        op.insert = 1'b0;
        op.pop    = 1'b0;
        op.status = ST_OK;
        if (request.func == FUNC_SEND)
        begin
            if (full)
                op.status = ST_FULL;
            else if (request.length > max_message_size)
                op.status = ST_TOO_LONG;
            else if (request.access_mode == MODE_READ_ONLY)
                op.status = ST_READ_ONLY;
            else
                op.insert = 1'b1;
        end
        else
        begin
            if (empty)
                op.status = ST_EMPTY;
            else if (max_message_size > request.length)
                op.status = ST_SMALL_BUF;
            else if (request.access_mode == MODE_WRITE_ONLY)
                op.status = ST_WRITE_ONLY;
            else
                op.pop = 1'b1;
        end
    end

endmodule

[rtl/core/pmq_cell.sv]
// one slot of the sorted chain: holds an entry, loads the new one or takes from a neighbor
// depends on pmq_pkg
`timescale 1ns / 1ps

module pmq_cell (
    input  logic                        clk,
    input  pmq_pkg::cell_ctrl_t         ctrl,
    input  logic [pmq_pkg::CNT_W-1:0]   index,
    input  pmq_pkg::entry_t             left_entry,
    input  logic                        left_keep,
    input  pmq_pkg::entry_t             right_entry,
    output pmq_pkg::entry_t             entry,
    output logic                        keep
);
    import pmq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;
    logic   occupied;

    assign occupied = (index < ctrl.count);
    // equal priority stays ahead of the new entry
    assign keep     = occupied && (entry_reg.prio <= ctrl.new_entry.prio);
    assign entry    = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.insert)
        begin
            if (keep)
                entry_next = entry_reg;
            else if (left_keep)
                entry_next = ctrl.new_entry;
            else
                entry_next = left_entry;
        end
        else if (ctrl.pop)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

[rtl/core/priority_message_queue_core.sv]
// top level of the sorted priority message queue
// depends on pmq_pkg, pmq_ctrl, pmq_cell and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Usage
// A request transfer happens at a rising edge with start high and busy low.
// request carries func, access_mode, payload_handle, length and priority_req.
// Exactly one result follows per request: result is valid for the single
// cycle in which done is high, which is the cycle after the request edge.
// A new request is taken every cycle; busy stays low because every cell
// of the chain settles its shift or insert at the request edge.
// Entries sit in a row of QUEUE_DEPTH cells sorted by priority; each cell
// compares its own priority with the incoming one and either holds, loads the
// new entry or copies a neighbor, so an insert or a removal needs no busy state.
// Configuration: cfg_index 0 sets max_messages, 1 sets max_message_size;
// writes are taken every cycle and belong in idle periods.
// Reset empties the queue (count to zero) and loads max_messages 100 and
// max_message_size 1000; cell contents are left as they are.
// The receiver has no way to stall: done and result must be captured when
// they appear.
module priority_message_queue_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  pmq_pkg::req_item_t                request,
    output logic                              done,
    output pmq_pkg::rsp_item_t                result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pmq_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pmq_pkg::LEN_W-1:0]         cfg_data
);
    import pmq_pkg::*;

    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [MAXMSG_W-1:0] max_messages_reg;
    logic [LEN_W-1:0]    max_message_size_reg;
    logic                done_reg;
    rsp_item_t           result_reg;
    rsp_item_t           result_next;

    logic       accept;
    op_t        op;
    cell_ctrl_t cell_ctrl;
    entry_t     cell_entry [QUEUE_DEPTH];
    logic       cell_keep  [QUEUE_DEPTH];

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;
    assign done      = done_reg;
    assign result    = result_reg;

    pmq_ctrl u_ctrl (
        .request          (request),
        .count            (count_reg),
        .max_messages     (max_messages_reg),
        .max_message_size (max_message_size_reg),
        .op               (op)
    );

    always_comb
    begin
        cell_ctrl.insert           = accept && op.insert;
        cell_ctrl.pop              = accept && op.pop;
        cell_ctrl.count            = count_reg;
        cell_ctrl.new_entry.handle = request.payload_handle;
        cell_ctrl.new_entry.length = request.length;
        cell_ctrl.new_entry.prio   = request.priority_req;
    end

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        entry_t left_entry;
        logic   left_keep;
        entry_t right_entry;

        if (i == 0)
        begin : g_head
            assign left_entry = cell_ctrl.new_entry;
            assign left_keep  = 1'b1;
        end
        else
        begin : g_body
            assign left_entry = cell_entry[i-1];
            assign left_keep  = cell_keep[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_tail
            assign right_entry = cell_entry[i];
        end
        else
        begin : g_inner
            assign right_entry = cell_entry[i+1];
        end

        pmq_cell u_cell (
            .clk         (clk),
            .ctrl        (cell_ctrl),
            .index       (CNT_W'(i)),
            .left_entry  (left_entry),
            .left_keep   (left_keep),
            .right_entry (right_entry),
            .entry       (cell_entry[i]),
            .keep        (cell_keep[i])
        );
    end

    always_comb
    begin
        count_next = count_reg;
        if (cell_ctrl.insert)
            count_next = count_reg + CNT_W'(1);
        else if (cell_ctrl.pop)
            count_next = count_reg - CNT_W'(1);
    end

    always_comb
    begin
        result_next        = '0;
        result_next.status = op.status;
        if (op.pop)
        begin
            result_next.out_handle   = cell_entry[0].handle;
            result_next.out_length   = cell_entry[0].length;
            result_next.out_priority = cell_entry[0].prio;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg            <= '0;
            done_reg             <= 1'b0;
            max_messages_reg     <= MAX_MESSAGES_RST;
            max_message_size_reg <= MAX_MESSAGE_SIZE_RST;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_MAX_MESSAGES:     max_messages_reg     <= cfg_data[MAXMSG_W-1:0];
                    REG_MAX_MESSAGE_SIZE: max_message_size_reg <= cfg_data;
                    default:              ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            result_reg <= result_next;
    end

    // count never passes the number of cells
    `PMQ_ASSERT_IMP(a_count_bound, 1'b1, CMP_W'(count_reg) <= CMP_W'(QUEUE_DEPTH))

    // a successful removal shrinks the queue by exactly one
    `PMQ_ASSERT_NXT(a_pop_count, cell_ctrl.pop, count_reg == $past(count_reg) - CNT_W'(1))

    // the two front cells stay in priority order
    `PMQ_ASSERT_IMP(a_head_sorted, count_reg >= CNT_W'(2),
                    cell_entry[0].prio <= cell_entry[1].prio)

    // every request transfer is answered by a result strobe
    `PMQ_ASSERT_NXT(a_done_follows, accept, done)

endmodule

[tb/sv/tb_priority_message_queue_core.sv]
`timescale 1ns / 1ps
// self-checking testbench for priority_message_queue_core: directed and random
// send/receive traffic scored against a behavioral sorted-queue predictor
// depends on pmq_pkg and the queue rtl
module tb_priority_message_queue_core;
    import pmq_pkg::*;

    localparam int CYCLE_LIMIT      = 200000;
    localparam int SHOWN_MISMATCHES = 10;
    // one-cycle gap after this percentage of transfers
    localparam int IDLE_PCT         = 23;

    localparam logic [1:0] MODE_READ_WRITE = 2'd0;
    localparam logic [1:0] MODE_UNUSED     = 2'd3;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    req_item_t            request;
    logic                 done;
    rsp_item_t            result;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [LEN_W-1:0]     cfg_data;

    // shadow copy of queue contents and registers
    entry_t    shadow_entries[$];
    int        max_messages_cfg;
    int        max_size_cfg;
    rsp_item_t expected_rsp_q[$];
    rsp_item_t oldest_rsp;

    bit          gaps_on;
    int unsigned cycle_cnt = 0;
    int unsigned fail_cnt = 0;
    int unsigned request_cnt = 0;
    int unsigned checked_cnt = 0;
    int unsigned setting_cnt = 0;
    int unsigned status_hits[8];

    priority_message_queue_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic rsp_item_t predict_queue_op(req_item_t req);
        rsp_item_t rsp;
        entry_t    ent;
        int        pos;
        rsp = '0;
        if (req.func == FUNC_SEND)
        begin
            if (shadow_entries.size() >= max_messages_cfg
                || shadow_entries.size() >= QUEUE_DEPTH)
                rsp.status = ST_FULL;
            else if (int'(req.length) > max_size_cfg)
                rsp.status = ST_TOO_LONG;
            else if (req.access_mode == MODE_READ_ONLY)
                rsp.status = ST_READ_ONLY;
            else
            begin
                ent.handle = req.payload_handle;
                ent.length = req.length;
                ent.prio   = req.priority_req;
                // behind every entry of equal or lower priority number
                pos = 0;
                while (pos < shadow_entries.size()
                       && shadow_entries[pos].prio <= req.priority_req)
                    pos++;
                shadow_entries.insert(pos, ent);
                rsp.status = ST_OK;
            end
        end
        else
        begin
            if (shadow_entries.size() == 0)
                rsp.status = ST_EMPTY;
            else if (int'(req.length) < max_size_cfg)
                rsp.status = ST_SMALL_BUF;
            else if (req.access_mode == MODE_WRITE_ONLY)
                rsp.status = ST_WRITE_ONLY;
            else
            begin
                ent = shadow_entries.pop_front();
                rsp.status       = ST_OK;
                rsp.out_handle   = ent.handle;
                rsp.out_length   = ent.length;
                rsp.out_priority = ent.prio;
            end
        end
        return rsp;
    endfunction

    function automatic req_item_t make_req(logic func, logic [1:0] mode,
                                           logic [HANDLE_W-1:0] handle, int len, int prio);
        req_item_t req;
        req.func           = func;
        req.access_mode    = mode;
        req.payload_handle = handle;
        req.length         = LEN_W'(len);
        req.priority_req   = PRIO_W'(prio);
        return req;
    endfunction

    function automatic req_item_t random_request(int send_pct);
        req_item_t   req;
        int unsigned pick;
        req.func           = ($urandom_range(99) < send_pct) ? FUNC_SEND : FUNC_RECEIVE;
        req.access_mode    = 2'($urandom_range(3));
        req.payload_handle = $urandom();
        req.length         = LEN_W'($urandom_range(1023));
        req.priority_req   = PRIO_W'($urandom_range(32767));
        if ($urandom_range(99) < 80)
        begin
            // legal length and a mode the operation allows
            if (req.func == FUNC_SEND)
            begin
                req.length = LEN_W'($urandom_range(max_size_cfg));
                if (req.access_mode == MODE_READ_ONLY)
                    req.access_mode = MODE_READ_WRITE;
            end
            else
            begin
                req.length = LEN_W'($urandom_range(1023, max_size_cfg));
                if (req.access_mode == MODE_WRITE_ONLY)
                    req.access_mode = MODE_UNUSED;
            end
        end
        // crowd priorities so ties are common
        pick = $urandom_range(9);
        if (pick < 4)
            req.priority_req = PRIO_W'($urandom_range(7));
        else if (pick == 4)
            req.priority_req = ($urandom_range(1) != 0) ? '1 : '0;
        return req;
    endfunction

    task automatic send_request(req_item_t req);
        request <= req;
        start   <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        expected_rsp_q.push_back(predict_queue_op(req));
        request_cnt++;
        if (gaps_on && $urandom_range(99) < IDLE_PCT)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic wait_queue_settled();
        start <= 1'b0;
        do
            @(posedge clk);
        while (expected_rsp_q.size() != 0);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [LEN_W-1:0] data);
        wait_queue_settled();
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == REG_MAX_MESSAGES)
            max_messages_cfg = int'(data[MAXMSG_W-1:0]);
        else
            max_size_cfg = int'(data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_settings(int max_msgs, int max_size);
        // top bits of the count write are outside the register
        write_register(REG_MAX_MESSAGES, {2'($urandom_range(3)), MAXMSG_W'(max_msgs)});
        write_register(REG_MAX_MESSAGE_SIZE, LEN_W'(max_size));
        setting_cnt++;
    endtask

    task automatic run_traffic(int n, int send_pct);
        repeat (n)
        begin
            send_request(random_request(send_pct));
            if ($urandom_range(99) == 0)
                wait_queue_settled();
        end
    endtask

    task automatic test_reset_defaults();
        send_request(make_req(FUNC_RECEIVE, MODE_READ_WRITE, 32'h1234_5678, 1023, 0));
        send_request(make_req(FUNC_RECEIVE, MODE_WRITE_ONLY, '0, 0, 0));
        send_request(make_req(FUNC_SEND, MODE_READ_WRITE, '1, 1000, 5));
        send_request(make_req(FUNC_SEND, MODE_READ_WRITE, 32'hdead_beef, 1001, 5));
        send_request(make_req(FUNC_SEND, MODE_READ_ONLY, 32'h0bad_f00d, 10, 5));
        send_request(make_req(FUNC_SEND, MODE_UNUSED, '0, 0, 5));
        send_request(make_req(FUNC_SEND, MODE_WRITE_ONLY, 32'h5a5a_a5a5, 1, 0));
        send_request(make_req(FUNC_SEND, MODE_READ_WRITE, 32'ha5a5_5a5a, 7, 32767));
        send_request(make_req(FUNC_RECEIVE, MODE_READ_WRITE, '0, 999, 0));
        send_request(make_req(FUNC_RECEIVE, MODE_WRITE_ONLY, '0, 1000, 0));
        send_request(make_req(FUNC_RECEIVE, MODE_READ_ONLY, '0, 1000, 0));
        send_request(make_req(FUNC_RECEIVE, MODE_UNUSED, '1, 1023, 32767));
        send_request(make_req(FUNC_RECEIVE, MODE_READ_WRITE, '0, 1000, 0));
        send_request(make_req(FUNC_RECEIVE, MODE_READ_WRITE, '0, 1000, 0));
        send_request(make_req(FUNC_RECEIVE, MODE_READ_WRITE, '0, 1000, 0));
    endtask

    task automatic test_register_extremes();
        // zero limit refuses every send, ahead of the length and mode checks
        write_register(REG_MAX_MESSAGES, 10'h300);
        send_request(make_req(FUNC_SEND, MODE_READ_WRITE, 32'h1, 5, 3));
        send_request(make_req(FUNC_SEND, MODE_READ_ONLY, 32'h2, 1023, 3));
        write_register(REG_MAX_MESSAGES, LEN_W'(2));
        write_register(REG_MAX_MESSAGE_SIZE, '0);
        send_request(make_req(FUNC_SEND, MODE_READ_WRITE, 32'h3, 0, 9));
        send_request(make_req(FUNC_SEND, MODE_READ_WRITE, 32'h4, 1, 9));
        send_request(make_req(FUNC_SEND, MODE_READ_ONLY, 32'h5, 0, 9));
        send_request(make_req(FUNC_SEND, MODE_UNUSED, 32'h6, 0, 0));
        send_request(make_req(FUNC_SEND, MODE_READ_ONLY, 32'h7, 1023, 0));
        send_request(make_req(FUNC_RECEIVE, MODE_READ_WRITE, '0, 0, 0));
        write_register(REG_MAX_MESSAGE_SIZE, '1);
        send_request(make_req(FUNC_RECEIVE, MODE_READ_WRITE, '0, 1022, 0));
        send_request(make_req(FUNC_RECEIVE, MODE_WRITE_ONLY, '0, 1023, 0));
        send_request(make_req(FUNC_RECEIVE, MODE_READ_WRITE, '0, 1023, 0));
        send_request(make_req(FUNC_RECEIVE, MODE_READ_WRITE, '0, 1023, 0));
        setting_cnt += 3;
    endtask

    task automatic test_small_limit_traffic();
        apply_settings(8, 512);
        run_traffic(200, 55);
    endtask

    task automatic test_depth_fill();
        // limit above the cell count, so the depth is what reports full
        gaps_on = 1'b0;
        apply_settings(255, 1023);
        run_traffic(250, 85);
        gaps_on = 1'b1;
    endtask

    task automatic test_lowered_limit();
        // queue is near full here; stored entries must survive the writes
        apply_settings(3, 0);
        run_traffic(150, 40);
    endtask

    task automatic test_single_slot();
        apply_settings(1, 300);
        run_traffic(150, 50);
    endtask

    task automatic test_mixed_traffic();
        apply_settings(128, 1000);
        run_traffic(250, 50);
    endtask

    task automatic test_random_settings();
        repeat (3)
        begin
            apply_settings($urandom_range(255), $urandom_range(1023));
            run_traffic(50, 50);
        end
    endtask

    // scoreboard: one result per request transfer, in order
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (expected_rsp_q.size() == 0)
            begin
                fail_cnt++;
                if (fail_cnt <= SHOWN_MISMATCHES)
                    $display("unexpected result: status %0d handle %h length %0d priority %0d",
                             result.status, result.out_handle, result.out_length,
                             result.out_priority);
            end
            else
            begin
                oldest_rsp = expected_rsp_q.pop_front();
                checked_cnt++;
                status_hits[oldest_rsp.status]++;
                if (result.status !== oldest_rsp.status
                    || result.out_handle !== oldest_rsp.out_handle
                    || result.out_length !== oldest_rsp.out_length
                    || result.out_priority !== oldest_rsp.out_priority)
                begin
                    fail_cnt++;
                    if (fail_cnt <= SHOWN_MISMATCHES)
                        $display({"result %0d: expected st %0d h %h len %0d pri %0d,",
                                  " got st %0d h %h len %0d pri %0d"},
                                 checked_cnt, oldest_rsp.status, oldest_rsp.out_handle,
                                 oldest_rsp.out_length, oldest_rsp.out_priority,
                                 result.status, result.out_handle, result.out_length,
                                 result.out_priority);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, expected_rsp_q.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        rst_n     <= 1'b0;
        start     <= 1'b0;
        request   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        max_messages_cfg = int'(MAX_MESSAGES_RST);
        max_size_cfg     = int'(MAX_MESSAGE_SIZE_RST);
        gaps_on          = 1'b1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_register_extremes();
        test_small_limit_traffic();
        test_depth_fill();
        test_lowered_limit();
        test_single_slot();
        test_mixed_traffic();
        test_random_settings();

        wait_queue_settled();
        repeat (4) @(posedge clk);
        $display("covered %0d requests and %0d checked results over %0d register settings",
                 request_cnt, checked_cnt, setting_cnt);
        $display({"statuses: ok %0d full %0d too long %0d read-only %0d",
                  " empty %0d small %0d write-only %0d"},
                 status_hits[ST_OK], status_hits[ST_FULL], status_hits[ST_TOO_LONG],
                 status_hits[ST_READ_ONLY], status_hits[ST_EMPTY], status_hits[ST_SMALL_BUF],
                 status_hits[ST_WRITE_ONLY]);
        if (fail_cnt == 0 && expected_rsp_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
